### hdl/jtl_pkg.sv
// jtl_pkg: token codes, character codes, run descriptor and keyword tables
// for the json token lexer. No dependencies; used by jtl_scan and json_token_lexer.
package jtl_pkg;

    // token type codes
    localparam logic [3:0] TOK_END      = 4'd0;
    localparam logic [3:0] TOK_ERROR    = 4'd1;
    localparam logic [3:0] TOK_LBRACE   = 4'd2;
    localparam logic [3:0] TOK_LBRACKET = 4'd3;
    localparam logic [3:0] TOK_RBRACE   = 4'd4;
    localparam logic [3:0] TOK_RBRACKET = 4'd5;
    localparam logic [3:0] TOK_COMMA    = 4'd6;
    localparam logic [3:0] TOK_COLON    = 4'd7;
    localparam logic [3:0] TOK_STRING   = 4'd8;
    localparam logic [3:0] TOK_NUMBER   = 4'd9;
    localparam logic [3:0] TOK_TRUE     = 4'd10;
    localparam logic [3:0] TOK_FALSE    = 4'd11;
    localparam logic [3:0] TOK_NULL     = 4'd12;

    // input mode codes
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // keyword kinds
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // character codes
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_UPPER_E   = 8'h45;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_L         = 8'h6C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_S         = 8'h73;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    // tokens caused by one input item: a run of keyword error tokens,
    // then up to two further tokens
    typedef struct packed {
        logic [2:0]  err_cnt;
        logic [31:0] err_base;
        logic [1:0]  err_room;
        logic        a_vld;
        logic [3:0]  a_type;
        logic [31:0] a_start;
        logic [31:0] a_len;
        logic        b_vld;
        logic [3:0]  b_type;
        logic [31:0] b_start;
        logic [31:0] b_len;
    } jtl_run_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // remaining keyword bytes after the first one
    function automatic logic [7:0] kw_tail(input logic [1:0] kind, input logic [1:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        case (kind)
            KW_TRUE:
            begin
                case (idx)
                    2'd0:    ch = CH_R;
                    2'd1:    ch = CH_U;
                    2'd2:    ch = CH_E;
                    default: ch = CH_NUL;
                endcase
            end
            KW_FALSE:
            begin
                case (idx)
                    2'd0:    ch = CH_A;
                    2'd1:    ch = CH_L;
                    2'd2:    ch = CH_S;
                    default: ch = CH_E;
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    ch = CH_U;
                    2'd1:    ch = CH_L;
                    2'd2:    ch = CH_L;
                    default: ch = CH_NUL;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            KW_FALSE: len = 3'd4;
            default:  len = 3'd3;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] kw_type(input logic [1:0] kind);
        logic [3:0] t;
        case (kind)
            KW_TRUE:  t = TOK_TRUE;
            KW_FALSE: t = TOK_FALSE;
            default:  t = TOK_NULL;
        endcase
        return t;
    endfunction

endpackage

### hdl/jtl_scan.sv
// jtl_scan: lexer state registers and the single-pass decode of one item
// into a token run descriptor. Depends on jtl_pkg.
module jtl_scan #(
    parameter int POSITION_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     mode,
    input  logic [7:0]               byte_value,
    output jtl_pkg::jtl_run_t        run,
    output logic [POSITION_BITS-1:0] position
);

    localparam logic [3:0] ST_IDLE          = 4'd0;
    localparam logic [3:0] ST_KEYWORD       = 4'd1;
    localparam logic [3:0] ST_STRING        = 4'd2;
    localparam logic [3:0] ST_NUM_MINUS     = 4'd3;
    localparam logic [3:0] ST_NUM_INT       = 4'd4;
    localparam logic [3:0] ST_NUM_AFTER_INT = 4'd5;
    localparam logic [3:0] ST_NUM_FRAC      = 4'd6;
    localparam logic [3:0] ST_NUM_EXP_SIGN  = 4'd7;
    localparam logic [3:0] ST_NUM_EXP_DIG   = 4'd8;

    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [POSITION_BITS-1:0] POS_THREE = POSITION_BITS'(3);

    logic [3:0]               state_reg,   state_next;
    logic [1:0]               kind_reg,    kind_next;
    logic [1:0]               matched_reg, matched_next;
    logic                     esc_reg,     esc_next;
    logic [POSITION_BITS-1:0] pos_reg,     pos_next;
    logic [POSITION_BITS-1:0] begin_reg,   begin_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] span;
    logic [POSITION_BITS-1:0] head;
    logic [1:0]               err_room;

    logic                     idle_vld;
    logic [3:0]               idle_type;
    logic [3:0]               idle_state;
    logic [1:0]               idle_kind;
    logic                     idle_esc;
    logic [POSITION_BITS-1:0] idle_begin;

    logic                     is_e;
    logic [3:0]               num_nx;
    logic                     kw_hit;
    logic [2:0]               kw_cnt;

    // saturating position step, span of the open token, room before saturation
    always_comb
    begin
        pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);
        span     = pos_reg - begin_reg;
        head     = POS_MAX - begin_reg;
        err_room = (head >= POS_THREE) ? 2'd3 : head[1:0];
    end

    // decode of a byte seen between tokens
    always_comb
    begin
        idle_vld   = 1'b0;
        idle_type  = jtl_pkg::TOK_ERROR;
        idle_state = ST_IDLE;
        idle_kind  = kind_reg;
        idle_esc   = esc_reg;
        idle_begin = begin_reg;
        case (byte_value)
            jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR:
            begin
                idle_vld = 1'b0;
            end
            jtl_pkg::CH_LBRACE:
            begin
                idle_vld  = 1'b1;
                idle_type = jtl_pkg::TOK_LBRACE;
            end
            jtl_pkg::CH_LBRACKET:
            begin
                idle_vld  = 1'b1;
                idle_type = jtl_pkg::TOK_LBRACKET;
            end
            jtl_pkg::CH_RBRACE:
            begin
                idle_vld  = 1'b1;
                idle_type = jtl_pkg::TOK_RBRACE;
            end
            jtl_pkg::CH_RBRACKET:
            begin
                idle_vld  = 1'b1;
                idle_type = jtl_pkg::TOK_RBRACKET;
            end
            jtl_pkg::CH_COMMA:
            begin
                idle_vld  = 1'b1;
                idle_type = jtl_pkg::TOK_COMMA;
            end
            jtl_pkg::CH_COLON:
            begin
                idle_vld  = 1'b1;
                idle_type = jtl_pkg::TOK_COLON;
            end
            jtl_pkg::CH_T:
            begin
                idle_state = ST_KEYWORD;
                idle_kind  = jtl_pkg::KW_TRUE;
                idle_begin = pos_reg;
            end
            jtl_pkg::CH_F:
            begin
                idle_state = ST_KEYWORD;
                idle_kind  = jtl_pkg::KW_FALSE;
                idle_begin = pos_reg;
            end
            jtl_pkg::CH_N:
            begin
                idle_state = ST_KEYWORD;
                idle_kind  = jtl_pkg::KW_NULL;
                idle_begin = pos_reg;
            end
            jtl_pkg::CH_QUOTE:
            begin
                idle_state = ST_STRING;
                idle_esc   = 1'b0;
                idle_begin = pos_inc;
            end
            jtl_pkg::CH_MINUS:
            begin
                idle_state = ST_NUM_MINUS;
                idle_begin = pos_reg;
            end
            jtl_pkg::CH_ZERO:
            begin
                idle_state = ST_NUM_AFTER_INT;
                idle_begin = pos_reg;
            end
            default:
            begin
                if (jtl_pkg::is_digit(byte_value))
                begin
                    idle_state = ST_NUM_INT;
                    idle_begin = pos_reg;
                end
                else
                begin
                    idle_vld = 1'b1;
                end
            end
        endcase
    end

    // number grammar: next state, or idle when the number ends before this byte
    always_comb
    begin
        is_e = (byte_value == jtl_pkg::CH_E) || (byte_value == jtl_pkg::CH_UPPER_E);
        case (state_reg)
            ST_NUM_MINUS:
            begin
                num_nx = (byte_value == jtl_pkg::CH_ZERO) ? ST_NUM_AFTER_INT : ST_NUM_INT;
            end
            ST_NUM_INT:
            begin
                if (jtl_pkg::is_digit(byte_value))
                    num_nx = ST_NUM_INT;
                else if (byte_value == jtl_pkg::CH_DOT)
                    num_nx = ST_NUM_FRAC;
                else
                    num_nx = is_e ? ST_NUM_EXP_SIGN : ST_IDLE;
            end
            ST_NUM_AFTER_INT:
            begin
                if (byte_value == jtl_pkg::CH_DOT)
                    num_nx = ST_NUM_FRAC;
                else
                    num_nx = is_e ? ST_NUM_EXP_SIGN : ST_IDLE;
            end
            ST_NUM_FRAC:
            begin
                if (jtl_pkg::is_digit(byte_value))
                    num_nx = ST_NUM_FRAC;
                else
                    num_nx = is_e ? ST_NUM_EXP_SIGN : ST_IDLE;
            end
            ST_NUM_EXP_SIGN:
            begin
                num_nx = ((byte_value == jtl_pkg::CH_PLUS) || (byte_value == jtl_pkg::CH_MINUS)
                          || jtl_pkg::is_digit(byte_value)) ? ST_NUM_EXP_DIG : ST_IDLE;
            end
            ST_NUM_EXP_DIG:
            begin
                num_nx = jtl_pkg::is_digit(byte_value) ? ST_NUM_EXP_DIG : ST_IDLE;
            end
            default:
            begin
                num_nx = ST_IDLE;
            end
        endcase
    end

    // keyword match of the current byte
    always_comb
    begin
        kw_hit = (byte_value == jtl_pkg::kw_tail(kind_reg, matched_reg));
        kw_cnt = {1'b0, matched_reg} + 3'd1;
    end

    // next state and token run for the item on the input
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        matched_next = matched_reg;
        esc_next     = esc_reg;
        pos_next     = pos_inc;
        begin_next   = begin_reg;

        run          = '0;
        run.err_base = 32'(begin_reg);
        run.err_room = err_room;

        if (mode == jtl_pkg::MODE_END)
        begin
            case (state_reg)
                ST_KEYWORD:
                begin
                    run.err_cnt = kw_cnt;
                    run.a_vld   = 1'b1;
                    run.a_type  = jtl_pkg::TOK_END;
                    run.a_start = 32'(pos_reg);
                end
                ST_STRING, ST_NUM_MINUS, ST_NUM_INT, ST_NUM_AFTER_INT, ST_NUM_FRAC,
                ST_NUM_EXP_SIGN, ST_NUM_EXP_DIG:
                begin
                    run.a_vld   = 1'b1;
                    run.a_type  = (state_reg == ST_STRING) ? jtl_pkg::TOK_STRING
                                                           : jtl_pkg::TOK_NUMBER;
                    run.a_start = 32'(begin_reg);
                    run.a_len   = 32'(span);
                    run.b_vld   = 1'b1;
                    run.b_type  = jtl_pkg::TOK_END;
                    run.b_start = 32'(pos_reg);
                end
                default:
                begin
                    run.a_vld   = 1'b1;
                    run.a_type  = jtl_pkg::TOK_END;
                    run.a_start = 32'(pos_reg);
                end
            endcase
            // the stream closes: back to the reset state
            state_next   = ST_IDLE;
            kind_next    = 2'd0;
            matched_next = 2'd0;
            esc_next     = 1'b0;
            pos_next     = '0;
            begin_next   = '0;
        end
        else
        begin
            case (state_reg)
                ST_KEYWORD:
                begin
                    if (kw_hit)
                    begin
                        matched_next = kw_cnt[1:0];
                        if (kw_cnt == jtl_pkg::kw_len(kind_reg))
                        begin
                            run.a_vld    = 1'b1;
                            run.a_type   = jtl_pkg::kw_type(kind_reg);
                            run.a_start  = 32'(begin_reg);
                            run.a_len    = 32'(kw_cnt) + 32'd1;
                            state_next   = ST_IDLE;
                            matched_next = 2'd0;
                        end
                    end
                    else
                    begin
                        // failed keyword: error per byte, then the byte lexed afresh
                        run.err_cnt  = kw_cnt;
                        run.a_vld    = idle_vld;
                        run.a_type   = idle_type;
                        run.a_start  = 32'(pos_reg);
                        run.a_len    = 32'd1;
                        state_next   = idle_state;
                        kind_next    = idle_kind;
                        matched_next = 2'd0;
                        esc_next     = idle_esc;
                        begin_next   = idle_begin;
                    end
                end
                ST_STRING:
                begin
                    if ((byte_value == jtl_pkg::CH_QUOTE) && !esc_reg)
                    begin
                        run.a_vld   = 1'b1;
                        run.a_type  = jtl_pkg::TOK_STRING;
                        run.a_start = 32'(begin_reg);
                        run.a_len   = 32'(span);
                        state_next  = ST_IDLE;
                    end
                    else if (byte_value == jtl_pkg::CH_QUOTE)
                    begin
                        esc_next = 1'b0;
                    end
                    else
                    begin
                        esc_next = (byte_value == jtl_pkg::CH_BACKSLASH);
                    end
                end
                ST_NUM_MINUS, ST_NUM_INT, ST_NUM_AFTER_INT, ST_NUM_FRAC,
                ST_NUM_EXP_SIGN, ST_NUM_EXP_DIG:
                begin
                    if (num_nx == ST_IDLE)
                    begin
                        run.a_vld   = 1'b1;
                        run.a_type  = jtl_pkg::TOK_NUMBER;
                        run.a_start = 32'(begin_reg);
                        run.a_len   = 32'(span);
                        run.b_vld   = idle_vld;
                        run.b_type  = idle_type;
                        run.b_start = 32'(pos_reg);
                        run.b_len   = 32'd1;
                        state_next  = idle_state;
                        kind_next   = idle_kind;
                        esc_next    = idle_esc;
                        begin_next  = idle_begin;
                    end
                    else
                    begin
                        state_next = num_nx;
                    end
                end
                default:
                begin
                    run.a_vld   = idle_vld;
                    run.a_type  = idle_type;
                    run.a_start = 32'(pos_reg);
                    run.a_len   = 32'd1;
                    state_next  = idle_state;
                    kind_next   = idle_kind;
                    esc_next    = idle_esc;
                    begin_next  = idle_begin;
                end
            endcase
        end
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kind_reg    <= 2'd0;
            matched_reg <= 2'd0;
            esc_reg     <= 1'b0;
            pos_reg     <= '0;
            begin_reg   <= '0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            matched_reg <= matched_next;
            esc_reg     <= esc_next;
            pos_reg     <= pos_next;
            begin_reg   <= begin_next;
        end
    end

    assign position = pos_reg;

endmodule

### hdl/json_token_lexer.sv
// json_token_lexer: streaming JSON lexer, one byte in, a run of tokens out.
// Input channel item_valid/item_ready carries mode and byte_value: mode 0 is
// a text byte, mode 1 closes the stream. Output channel token_valid/
// token_ready carries token_type, token_start, token_length and last_of_run,
// which marks the final token caused by one input item.
// Latency: the first token of an item is valid in the cycle after its transfer.
// Throughput: one item per cycle while each item causes at most one token and
// token_ready stays high. An item that causes several tokens holds item_ready
// low until its last token transfers; the single output register drains one
// token a cycle while token_ready is high (at most five tokens: a failed keyword
// or a close of stream). Items that cause no token (whitespace, bytes inside
// strings or numbers) leave item_ready high.
// Reset clears the lexer state, the byte position and any pending tokens.
// When the receiver stalls, the current token holds and item_ready stays low
// until the last token of the pending run transfers.
// Depends on jtl_pkg and jtl_scan.
module json_token_lexer #(
    parameter int POSITION_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        mode,
    input  logic [7:0]  byte_value,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [3:0]  token_type,
    output logic [31:0] token_start,
    output logic [31:0] token_length,
    output logic        last_of_run
);

    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [31:0]              START_SAT = 32'(POS_MAX);

    jtl_pkg::jtl_run_t        run_next;
    jtl_pkg::jtl_run_t        run_reg;
    logic [1:0]               off_reg;
    logic [POSITION_BITS-1:0] position;

    logic                     item_xfer;
    logic                     token_xfer;
    logic [2:0]               left;
    logic [31:0]              err_start;

    assign item_xfer  = item_valid && item_ready;
    assign token_xfer = token_valid && token_ready;

    jtl_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (item_xfer),
        .mode       (mode),
        .byte_value (byte_value),
        .run        (run_next),
        .position   (position)
    );

    // tokens still to be shown and input flow control
    always_comb
    begin
        left        = run_reg.err_cnt + {2'b00, run_reg.a_vld} + {2'b00, run_reg.b_vld};
        token_valid = (left != 3'd0);
        item_ready  = (left == 3'd0) || ((left == 3'd1) && token_ready);
    end

    // current token of the run: keyword errors first, then a, then b
    always_comb
    begin
        err_start = (off_reg <= run_reg.err_room) ? run_reg.err_base + 32'(off_reg)
                                                  : START_SAT;
        if (run_reg.err_cnt != 3'd0)
        begin
            token_type   = jtl_pkg::TOK_ERROR;
            token_start  = err_start;
            token_length = 32'd1;
        end
        else if (run_reg.a_vld)
        begin
            token_type   = run_reg.a_type;
            token_start  = run_reg.a_start;
            token_length = run_reg.a_len;
        end
        else
        begin
            token_type   = run_reg.b_type;
            token_start  = run_reg.b_start;
            token_length = run_reg.b_len;
        end
        last_of_run = (left == 3'd1);
    end

    // run register: loaded on an input transfer, drained one token per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            off_reg <= 2'd0;
        end
        else if (item_xfer)
        begin
            run_reg <= run_next;
            off_reg <= 2'd0;
        end
        else if (token_xfer)
        begin
            if (run_reg.err_cnt != 3'd0)
            begin
                run_reg.err_cnt <= run_reg.err_cnt - 3'd1;
                off_reg         <= off_reg + 2'd1;
            end
            else if (run_reg.a_vld)
            begin
                run_reg.a_vld <= 1'b0;
            end
            else
            begin
                run_reg.b_vld <= 1'b0;
            end
        end
    end

    // checks
    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_type == jtl_pkg::TOK_END) |-> (token_length == 32'd0) && last_of_run)
        else $error("end token not last or of non-zero length");

    a_error_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_type == jtl_pkg::TOK_ERROR) |-> (token_length == 32'd1))
        else $error("error token length not one");

    a_close_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && (mode == jtl_pkg::MODE_END) |=> token_valid && (position == '0))
        else $error("close of stream gave no token or left the position set");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !token_valid |-> item_ready)
        else $error("input stalled with no token pending");

endmodule

### dv/json_token_lexer_tb.sv
// json_token_lexer_tb: self-checking testbench for the streaming json lexer.
// Holds its own token predictor and scoreboard, a directed table and random documents.
// Depends on jtl_pkg and the json_token_lexer top level.
`timescale 1ns / 1ps

module json_token_lexer_tb;

    localparam int          RANDOM_ITEMS = 320;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          TAIL_CYCLES  = 20;
    localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;

    // lexer phases of the predictor
    typedef enum logic [3:0] {
        LX_IDLE,
        LX_KEYWORD,
        LX_STRING,
        LX_NUM_MINUS,
        LX_NUM_INT,
        LX_NUM_AFTER_INT,
        LX_NUM_FRAC,
        LX_NUM_EXP_SIGN,
        LX_NUM_EXP_DIG
    } lex_phase_t;

    typedef struct packed {
        logic [3:0]  ty;
        logic [31:0] start;
        logic [31:0] len;
        logic        last;
    } lex_token_t;

    typedef struct packed {
        logic       m;
        logic [7:0] b;
        logic       typed;
        lex_token_t tok;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        mode = jtl_pkg::MODE_DATA;
    logic [7:0]  byte_value = 8'h00;
    logic        token_valid;
    logic        token_ready = 1'b0;
    logic [3:0]  token_type;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        last_of_run;

    // predictor state
    lex_phase_t  m_phase;
    logic [1:0]  m_kw_kind;
    logic [1:0]  m_kw_hits;
    logic        m_escape;
    logic [31:0] m_pos;
    logic [31:0] m_begin;

    lex_token_t  item_run[$];
    lex_token_t  pending_tokens[$];
    stim_row_t   directed_rows[$];
    logic [8:0]  byte_plan[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;

    json_token_lexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .byte_value   (byte_value),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_type   (token_type),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] pos_plus(input logic [31:0] a, input logic [31:0] k);
        if (a > POS_MAX - k)
            return POS_MAX;
        return a + k;
    endfunction

    function automatic logic digit(input logic [7:0] b);
        return (b >= jtl_pkg::CH_ZERO) && (b <= jtl_pkg::CH_NINE);
    endfunction

    // byte expected after idx matched bytes of a keyword
    function automatic logic [7:0] kw_expected(input logic [1:0] kind, input logic [1:0] idx);
        logic [31:0] word;
        case (kind)
            jtl_pkg::KW_TRUE:
                word = {jtl_pkg::CH_R, jtl_pkg::CH_U, jtl_pkg::CH_E, jtl_pkg::CH_NUL};
            jtl_pkg::KW_FALSE:
                word = {jtl_pkg::CH_A, jtl_pkg::CH_L, jtl_pkg::CH_S, jtl_pkg::CH_E};
            default:
                word = {jtl_pkg::CH_U, jtl_pkg::CH_L, jtl_pkg::CH_L, jtl_pkg::CH_NUL};
        endcase
        return word[31 - 8 * idx -: 8];
    endfunction

    task automatic lex_clear();
        m_phase   = LX_IDLE;
        m_kw_kind = jtl_pkg::KW_TRUE;
        m_kw_hits = 2'd0;
        m_escape  = 1'b0;
        m_pos     = 32'd0;
        m_begin   = 32'd0;
    endtask

    task automatic add_tok(input logic [3:0] ty, input logic [31:0] st, input logic [31:0] ln);
        lex_token_t t;
        t.ty    = ty;
        t.start = st;
        t.len   = ln;
        t.last  = 1'b0;
        item_run.push_back(t);
    endtask

    // first byte plus each matched byte become error tokens
    task automatic keyword_errors();
        add_tok(jtl_pkg::TOK_ERROR, m_begin, 32'd1);
        for (int i = 1; i <= m_kw_hits; i++)
            add_tok(jtl_pkg::TOK_ERROR, pos_plus(m_begin, 32'(i)), 32'd1);
        m_phase   = LX_IDLE;
        m_kw_hits = 2'd0;
    endtask

    task automatic lex_from_idle(input logic [7:0] b, input logic [31:0] pos);
        m_phase = LX_IDLE;
        case (b)
            jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR: ;
            jtl_pkg::CH_LBRACE:   add_tok(jtl_pkg::TOK_LBRACE, pos, 32'd1);
            jtl_pkg::CH_LBRACKET: add_tok(jtl_pkg::TOK_LBRACKET, pos, 32'd1);
            jtl_pkg::CH_RBRACE:   add_tok(jtl_pkg::TOK_RBRACE, pos, 32'd1);
            jtl_pkg::CH_RBRACKET: add_tok(jtl_pkg::TOK_RBRACKET, pos, 32'd1);
            jtl_pkg::CH_COMMA:    add_tok(jtl_pkg::TOK_COMMA, pos, 32'd1);
            jtl_pkg::CH_COLON:    add_tok(jtl_pkg::TOK_COLON, pos, 32'd1);
            jtl_pkg::CH_T, jtl_pkg::CH_F, jtl_pkg::CH_N:
            begin
                m_phase   = LX_KEYWORD;
                m_kw_kind = (b == jtl_pkg::CH_T) ? jtl_pkg::KW_TRUE :
                            (b == jtl_pkg::CH_F) ? jtl_pkg::KW_FALSE : jtl_pkg::KW_NULL;
                m_kw_hits = 2'd0;
                m_begin   = pos;
            end
            jtl_pkg::CH_QUOTE:
            begin
                m_phase  = LX_STRING;
                m_escape = 1'b0;
                m_begin  = pos_plus(pos, 32'd1);
            end
            jtl_pkg::CH_MINUS:
            begin
                m_phase = LX_NUM_MINUS;
                m_begin = pos;
            end
            jtl_pkg::CH_ZERO:
            begin
                m_phase = LX_NUM_AFTER_INT;
                m_begin = pos;
            end
            default:
            begin
                if (digit(b))
                begin
                    m_phase = LX_NUM_INT;
                    m_begin = pos;
                end
                else
                    add_tok(jtl_pkg::TOK_ERROR, pos, 32'd1);
            end
        endcase
    endtask

    // next number phase, idle when the number ends before this byte
    function automatic lex_phase_t num_follow(input lex_phase_t ph, input logic [7:0] b);
        logic       exp_mark;
        lex_phase_t nx;
        exp_mark = (b == jtl_pkg::CH_E) || (b == jtl_pkg::CH_UPPER_E);
        nx = LX_IDLE;
        case (ph)
            LX_NUM_MINUS:
                nx = (b == jtl_pkg::CH_ZERO) ? LX_NUM_AFTER_INT : LX_NUM_INT;
            LX_NUM_INT:
            begin
                if (digit(b))
                    nx = LX_NUM_INT;
                else if (b == jtl_pkg::CH_DOT)
                    nx = LX_NUM_FRAC;
                else if (exp_mark)
                    nx = LX_NUM_EXP_SIGN;
            end
            LX_NUM_AFTER_INT:
            begin
                if (b == jtl_pkg::CH_DOT)
                    nx = LX_NUM_FRAC;
                else if (exp_mark)
                    nx = LX_NUM_EXP_SIGN;
            end
            LX_NUM_FRAC:
            begin
                if (digit(b))
                    nx = LX_NUM_FRAC;
                else if (exp_mark)
                    nx = LX_NUM_EXP_SIGN;
            end
            LX_NUM_EXP_SIGN:
            begin
                if (b == jtl_pkg::CH_PLUS || b == jtl_pkg::CH_MINUS || digit(b))
                    nx = LX_NUM_EXP_DIG;
            end
            LX_NUM_EXP_DIG:
            begin
                if (digit(b))
                    nx = LX_NUM_EXP_DIG;
            end
            default: ;
        endcase
        return nx;
    endfunction

    // tokens caused by one accepted item, left in item_run
    task automatic tokens_for_item(input logic m, input logic [7:0] b);
        logic [31:0] pos;
        logic [2:0]  hits;
        lex_phase_t  nx;
        item_run.delete();
        pos = m_pos;
        if (m == jtl_pkg::MODE_END)
        begin
            if (m_phase == LX_KEYWORD)
                keyword_errors();
            else if (m_phase == LX_STRING)
                add_tok(jtl_pkg::TOK_STRING, m_begin, pos - m_begin);
            else if (m_phase >= LX_NUM_MINUS)
                add_tok(jtl_pkg::TOK_NUMBER, m_begin, pos - m_begin);
            add_tok(jtl_pkg::TOK_END, pos, 32'd0);
            lex_clear();
        end
        else
        begin
            case (m_phase)
                LX_KEYWORD:
                begin
                    if (b == kw_expected(m_kw_kind, m_kw_hits))
                    begin
                        hits = {1'b0, m_kw_hits} + 3'd1;
                        m_kw_hits = hits[1:0];
                        if (hits == ((m_kw_kind == jtl_pkg::KW_FALSE) ? 3'd4 : 3'd3))
                        begin
                            add_tok((m_kw_kind == jtl_pkg::KW_TRUE) ? jtl_pkg::TOK_TRUE :
                                    (m_kw_kind == jtl_pkg::KW_FALSE) ? jtl_pkg::TOK_FALSE :
                                    jtl_pkg::TOK_NULL,
                                    m_begin, hits + 32'd1);
                            m_phase   = LX_IDLE;
                            m_kw_hits = 2'd0;
                        end
                    end
                    else
                    begin
                        keyword_errors();
                        lex_from_idle(b, pos);
                    end
                end
                LX_STRING:
                begin
                    if (b == jtl_pkg::CH_QUOTE && !m_escape)
                    begin
                        add_tok(jtl_pkg::TOK_STRING, m_begin, pos - m_begin);
                        m_phase = LX_IDLE;
                    end
                    else if (b == jtl_pkg::CH_QUOTE)
                        m_escape = 1'b0;
                    else
                        m_escape = (b == jtl_pkg::CH_BACKSLASH);
                end
                LX_IDLE:
                    lex_from_idle(b, pos);
                default:
                begin
                    nx = num_follow(m_phase, b);
                    if (nx == LX_IDLE)
                    begin
                        add_tok(jtl_pkg::TOK_NUMBER, m_begin, pos - m_begin);
                        lex_from_idle(b, pos);
                    end
                    else
                        m_phase = nx;
                end
            endcase
            m_pos = pos_plus(pos, 32'd1);
        end
    endtask

    // ---------------------------------------------------------------- driving

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one item on the input channel, then its predicted tokens are queued
    task automatic send_item(input logic m, input logic [7:0] b, input logic typed,
                             input lex_token_t want);
        int         gap;
        lex_token_t t;
        gap = calm ? 0 : rand_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            mode       <= 1'($urandom_range(0, 1));
            byte_value <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode       <= m;
        byte_value <= b;
        do
            @(posedge clk);
        while (!item_ready);
        tokens_for_item(m, b);
        if (typed)
        begin
            t = want;
            t.last = 1'b1;
            pending_tokens.push_back(t);
        end
        else
        begin
            for (int i = 0; i < item_run.size(); i++)
            begin
                t = item_run[i];
                t.last = (i == item_run.size() - 1);
                pending_tokens.push_back(t);
            end
        end
        items_sent++;
    endtask

    // sender holds off until the scoreboard is empty
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
    endtask

    task automatic table_row(input logic m, input logic [7:0] b, input logic typed,
                             input logic [3:0] ty, input logic [31:0] st,
                             input logic [31:0] ln);
        stim_row_t r;
        r.m         = m;
        r.b         = b;
        r.typed     = typed;
        r.tok.ty    = ty;
        r.tok.start = st;
        r.tok.len   = ln;
        r.tok.last  = 1'b1;
        directed_rows.push_back(r);
    endtask

    // ---------------------------------------------------------------- text generation

    task automatic put(input logic [7:0] b);
        byte_plan.push_back({jtl_pkg::MODE_DATA, b});
    endtask

    task automatic gen_ws();
        if ($urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                case ($urandom_range(0, 3))
                    0:       put(jtl_pkg::CH_SPACE);
                    1:       put(jtl_pkg::CH_TAB);
                    2:       put(jtl_pkg::CH_LF);
                    default: put(jtl_pkg::CH_CR);
                endcase
            end
        end
    endtask

    function automatic logic [7:0] kw_byte(input int kind, input int idx);
        logic [39:0] w;
        case (kind)
            0:
                w = {jtl_pkg::CH_T, jtl_pkg::CH_R, jtl_pkg::CH_U, jtl_pkg::CH_E,
                     jtl_pkg::CH_NUL};
            1:
                w = {jtl_pkg::CH_F, jtl_pkg::CH_A, jtl_pkg::CH_L, jtl_pkg::CH_S,
                     jtl_pkg::CH_E};
            default:
                w = {jtl_pkg::CH_N, jtl_pkg::CH_U, jtl_pkg::CH_L, jtl_pkg::CH_L,
                     jtl_pkg::CH_NUL};
        endcase
        return w[39 - 8 * idx -: 8];
    endfunction

    task automatic gen_keyword(input int kind, input int count);
        for (int i = 0; i < count; i++)
            put(kw_byte(kind, i));
    endtask

    task automatic gen_string();
        logic [7:0] ch;
        put(jtl_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    put(jtl_pkg::CH_BACKSLASH);
                    put(($urandom_range(0, 1) == 0) ? jtl_pkg::CH_QUOTE : jtl_pkg::CH_BACKSLASH);
                end
                2:
                    put(8'($urandom_range(8'h80, 8'hFF)));
                default:
                begin
                    ch = 8'($urandom_range(8'h20, 8'h7E));
                    put((ch == jtl_pkg::CH_QUOTE || ch == jtl_pkg::CH_BACKSLASH) ?
                        jtl_pkg::CH_A : ch);
                end
            endcase
        end
        put(jtl_pkg::CH_QUOTE);
    endtask

    task automatic gen_number();
        if ($urandom_range(0, 2) == 0)
            put(jtl_pkg::CH_MINUS);
        if ($urandom_range(0, 3) == 0)
            put(jtl_pkg::CH_ZERO);
        else
        begin
            put(8'($urandom_range(8'h31, jtl_pkg::CH_NINE)));
            repeat ($urandom_range(0, 2))
                put(8'($urandom_range(jtl_pkg::CH_ZERO, jtl_pkg::CH_NINE)));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            put(jtl_pkg::CH_DOT);
            repeat ($urandom_range(1, 3))
                put(8'($urandom_range(jtl_pkg::CH_ZERO, jtl_pkg::CH_NINE)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            put(($urandom_range(0, 1) == 0) ? jtl_pkg::CH_E : jtl_pkg::CH_UPPER_E);
            case ($urandom_range(0, 2))
                0:       put(jtl_pkg::CH_PLUS);
                1:       put(jtl_pkg::CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(1, 2))
                put(8'($urandom_range(jtl_pkg::CH_ZERO, jtl_pkg::CH_NINE)));
        end
    endtask

    task automatic gen_scalar();
        int kind;
        case ($urandom_range(0, 2))
            0:       gen_string();
            1:       gen_number();
            default:
            begin
                kind = $urandom_range(0, 2);
                gen_keyword(kind, (kind == 1) ? 5 : 4);
            end
        endcase
    endtask

    // array or object holding scalars only
    task automatic gen_flat();
        int n;
        logic is_obj;
        is_obj = 1'($urandom_range(0, 1));
        n = $urandom_range(0, 3);
        put(is_obj ? jtl_pkg::CH_LBRACE : jtl_pkg::CH_LBRACKET);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                put(jtl_pkg::CH_COMMA);
            gen_ws();
            if (is_obj)
            begin
                gen_string();
                gen_ws();
                put(jtl_pkg::CH_COLON);
                gen_ws();
            end
            gen_scalar();
            gen_ws();
        end
        put(is_obj ? jtl_pkg::CH_RBRACE : jtl_pkg::CH_RBRACKET);
    endtask

    task automatic gen_value();
        if ($urandom_range(0, 9) < 3)
            gen_flat();
        else
            gen_scalar();
    endtask

    task automatic gen_doc();
        int n;
        int r;
        r = $urandom_range(0, 9);
        gen_ws();
        if (r < 5)
        begin
            put(jtl_pkg::CH_LBRACKET);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    put(jtl_pkg::CH_COMMA);
                gen_ws();
                gen_value();
                gen_ws();
            end
            put(jtl_pkg::CH_RBRACKET);
        end
        else if (r < 8)
        begin
            put(jtl_pkg::CH_LBRACE);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    put(jtl_pkg::CH_COMMA);
                gen_ws();
                gen_string();
                put(jtl_pkg::CH_COLON);
                gen_ws();
                gen_value();
            end
            put(jtl_pkg::CH_RBRACE);
        end
        else
            gen_value();
        gen_ws();
    endtask

    // broken keywords, odd numbers and raw bytes
    task automatic gen_noise();
        int kind;
        case ($urandom_range(0, 3))
            0:
                repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
            1, 2:
            begin
                kind = $urandom_range(0, 2);
                gen_keyword(kind, $urandom_range(1, (kind == 1) ? 4 : 3));
                if ($urandom_range(0, 1) == 0)
                    put(8'($urandom_range(0, 255)));
                else
                    put(($urandom_range(0, 1) == 0) ? jtl_pkg::CH_RBRACE : jtl_pkg::CH_COMMA);
            end
            default:
            begin
                put(($urandom_range(0, 1) == 0) ? jtl_pkg::CH_MINUS : jtl_pkg::CH_ZERO);
                put(8'($urandom_range(0, 255)));
                put(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // ---------------------------------------------------------------- receiver

    initial
    begin : ready_gen
        int gap;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            token_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (!calm)
            begin
                gap = rand_gap();
                if (gap > 0)
                begin
                    token_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------- scoreboard

    always @(posedge clk)
    begin : token_check
        lex_token_t want;
        if (token_valid && token_ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("unexpected token: type %0d start %0d length %0d",
                       token_type, token_start, token_length);
                mismatch_count++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (token_type !== want.ty)
                begin
                    $error("token_type: expected %0d, got %0d", want.ty, token_type);
                    mismatch_count++;
                end
                if (token_start !== want.start)
                begin
                    $error("token_start: expected %0d, got %0d", want.start, token_start);
                    mismatch_count++;
                end
                if (token_length !== want.len)
                begin
                    $error("token_length: expected %0d, got %0d", want.len, token_length);
                    mismatch_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (token_valid && token_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin : stimulus
        stim_row_t  row;
        lex_token_t none;
        int         target;
        none = '0;
        lex_clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: punctuation, byte extremes, escapes, keyword and
        // number cases, close of stream with work pending
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_LBRACE,    1'b1, jtl_pkg::TOK_LBRACE,
                  32'd0, 32'd1);
        table_row(jtl_pkg::MODE_DATA, 8'h00,                 1'b1, jtl_pkg::TOK_ERROR,
                  32'd1, 32'd1);
        table_row(jtl_pkg::MODE_DATA, 8'hFF,                 1'b1, jtl_pkg::TOK_ERROR,
                  32'd2, 32'd1);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_QUOTE,     1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_BACKSLASH, 1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_QUOTE,     1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_QUOTE,     1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_N,         1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, 8'h78,                 1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_MINUS,     1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_ZERO,      1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_DOT,       1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, 8'h35,                 1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_E,         1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_PLUS,      1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_NINE,      1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_END,  8'h00,                 1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_F,         1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_A,         1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_L,         1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_S,         1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_END,  8'h00,                 1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_QUOTE,     1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_DATA, jtl_pkg::CH_A,         1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_END,  8'h00,                 1'b0, jtl_pkg::TOK_END,
                  32'd0, 32'd0);
        table_row(jtl_pkg::MODE_END,  8'hFF,                 1'b1, jtl_pkg::TOK_END,
                  32'd0, 32'd0);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item(row.m, row.b, row.typed, row.tok);
        end
        hold_until_drained();

        // random documents, mostly well formed, with noise and stream ends
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0)
                gen_noise();
            else
                gen_doc();
            if ($urandom_range(0, 3) == 0)
                byte_plan.push_back({jtl_pkg::MODE_END, 8'($urandom_range(0, 255))});
            while (byte_plan.size() != 0)
            begin
                row.m = byte_plan[0][8];
                row.b = byte_plan[0][7:0];
                void'(byte_plan.pop_front());
                send_item(row.m, row.b, 1'b0, none);
            end
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        // drain and let the pipeline settle
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_tokens.size() != 0)
        begin
            $error("%0d expected tokens never arrived", pending_tokens.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
